>>> rtl/core/lbp_pkg.sv
// Shared constants and types for the 3x3 local binary pattern stream block.
package lbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int MIN_SIDE   = 3;

  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int LINE_W     = 2 * PIX_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [FW_W-1:0] FW_RESET = FW_W'(640);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(480);

  localparam int FIFO_DEPTH = 3;
  localparam int FIFO_PTR_W = 2;
  localparam int FIFO_CNT_W = 2;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } s1_ctrl_t;

  typedef struct packed {
    logic [7:0] code;
    logic       done;
  } result_t;

endpackage

>>> rtl/core/lbp_3x3_code_stream_top.sv
// Top level of the streaming 3x3 local binary pattern code generator.
//
//  channel | direction | ports                                  | transaction
//  --------+-----------+----------------------------------------+------------------------
//  in      | input     | in_valid, in_ready, in_pixel           | one raster-order pixel
//  out     | output    | out_valid, out_ready, out_pattern_code, | one interior LBP code
//          |           | out_frame_done                         |
//  cfg     | input     | cfg_valid, cfg_ready, cfg_index,        | one register write
//          |           | cfg_data                               |
//
// One pixel per clock sustained while the output queue has room. A pixel is
// registered with its column while the line RAM (one 16-bit row pair, 1024 deep)
// is read; the next cycle updates the window and lands the code in a 3-entry
// output queue. in_ready drops only when the queue plus the code in flight fill it.
// Reset: counters, window and queue clear; line RAM content is not cleared.
module lbp_3x3_code_stream_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  lbp_pkg::pixel_t               in_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_pattern_code,
  output logic                          out_frame_done,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lbp_pkg::*;

  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [FW_W-1:0]  w_eff;
  logic [FH_W-1:0]  h_eff;

  logic [COL_W-1:0] col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [FW_W-1:0]  col_inc;
  logic [FH_W-1:0]  row_inc;
  logic             last_col;
  logic             last_row;
  logic             in_fire;

  s1_ctrl_t         s1_r, s1_nxt;
  pixel_t           s1_px_r;
  logic [COL_W-1:0] s1_col_r;

  logic [LINE_W-1:0] line_rdata;
  logic [LINE_W-1:0] line_wdata;
  pixel_t            top_px;
  pixel_t            mid_px;

  logic                  push;
  result_t               push_data;
  result_t               out_data;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   occupancy;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= FW_RESET;
      fh_r <= FH_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  fw_r <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT: fh_r <= cfg_data[FH_W-1:0];
        default:          ;
      endcase
    end
  end

  assign w_eff = (fw_r < FW_W'(MIN_SIDE))  ? FW_W'(MIN_SIDE)  :
                 (fw_r > FW_W'(MAX_WIDTH)) ? FW_W'(MAX_WIDTH) : fw_r;
  assign h_eff = (fh_r < FH_W'(MIN_SIDE))   ? FH_W'(MIN_SIDE)   :
                 (fh_r > FH_W'(MAX_HEIGHT)) ? FH_W'(MAX_HEIGHT) : fh_r;

  // input stage: position counters
  assign occupancy = {1'b0, fifo_count} + (FIFO_CNT_W + 1)'(push);
  assign in_ready  = occupancy < (FIFO_CNT_W + 1)'(FIFO_DEPTH);
  assign in_fire   = in_valid && in_ready;

  assign col_inc  = FW_W'(col_r) + FW_W'(1);
  assign row_inc  = FH_W'(row_r) + FH_W'(1);
  assign last_col = col_inc >= w_eff;
  assign last_row = row_inc >= h_eff;

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = last_row ? '0 : row_inc[ROW_W-1:0];
      end else begin
        col_nxt = col_inc[COL_W-1:0];
      end
    end
    s1_nxt.valid = in_fire;
    s1_nxt.emit  = (row_r >= ROW_W'(2)) && (col_r >= COL_W'(2));
    s1_nxt.last  = last_row && last_col;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      s1_r  <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      s1_r  <= s1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r  <= in_pixel;
      s1_col_r <= col_r;
    end
  end

  // line buffers: upper row in the low byte, middle row in the high byte
  assign top_px     = line_rdata[PIX_W-1:0];
  assign mid_px     = line_rdata[LINE_W-1:PIX_W];
  assign line_wdata = {s1_px_r, mid_px};

  lbp_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (s1_r.valid),
    .waddr (s1_col_r),
    .wdata (line_wdata),
    .re    (in_fire),
    .raddr (col_r),
    .rdata (line_rdata)
  );

  lbp_window u_window (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (s1_r),
    .top_px (top_px),
    .mid_px (mid_px),
    .new_px (s1_px_r),
    .push   (push),
    .res    (push_data)
  );

  lbp_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .count     (fifo_count)
  );

  assign out_pattern_code = out_data.code;
  assign out_frame_done   = out_data.done;

endmodule

>>> rtl/core/lbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lbp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/lbp_window.sv
// 3x3 sliding window and LBP code compare stage.
module lbp_window (
  input  logic              clk,
  input  logic              rst_n,
  input  lbp_pkg::s1_ctrl_t ctrl,
  input  lbp_pkg::pixel_t   top_px,
  input  lbp_pkg::pixel_t   mid_px,
  input  lbp_pkg::pixel_t   new_px,
  output logic              push,
  output lbp_pkg::result_t  res
);
  import lbp_pkg::*;

  pixel_t win_r   [3][3];
  pixel_t win_nxt [3][3];
  pixel_t ctr;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      win_nxt[i][0] = win_r[i][1];
      win_nxt[i][1] = win_r[i][2];
    end
    win_nxt[0][2] = top_px;
    win_nxt[1][2] = mid_px;
    win_nxt[2][2] = new_px;
  end

  assign ctr = win_nxt[1][1];

  always_comb begin
    res.code[0] = win_nxt[0][0] >= ctr;
    res.code[1] = win_nxt[0][1] >= ctr;
    res.code[2] = win_nxt[0][2] >= ctr;
    res.code[3] = win_nxt[1][0] >= ctr;
    res.code[4] = win_nxt[1][2] >= ctr;
    res.code[5] = win_nxt[2][0] >= ctr;
    res.code[6] = win_nxt[2][1] >= ctr;
    res.code[7] = win_nxt[2][2] >= ctr;
    res.done    = ctrl.last;
  end

  assign push = ctrl.valid && ctrl.emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_r[i][j] <= '0;
        end
      end
    end else if (ctrl.valid) begin
      win_r <= win_nxt;
    end
  end

endmodule

>>> rtl/core/lbp_out_fifo.sv
// Small result queue that decouples the compare stage from the output channel.
module lbp_out_fifo (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  lbp_pkg::result_t               push_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output lbp_pkg::result_t               out_data,
  output logic [lbp_pkg::FIFO_CNT_W-1:0] count
);
  import lbp_pkg::*;

  result_t               mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  pop;

  assign out_valid = (cnt_r != '0);
  assign out_data  = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign count     = cnt_r;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

>>> sim/lbp_3x3_code_stream_tb.sv
// Self-checking testbench for the streaming 3x3 local binary pattern code block.
module testbench;
  import lbp_pkg::*;

  localparam int HALF_PERIOD   = 10;
  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES   = 120;
  localparam int RANDOM_PIXELS = 770;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = CFG_IDX_W'(3);

  class lbp_window_tracker;
    logic [FW_W-1:0] width_reg;
    logic [FH_W-1:0] height_reg;
    pixel_t          upper_row[MAX_WIDTH];
    pixel_t          middle_row[MAX_WIDTH];
    pixel_t          win[3][3];
    int unsigned     row, col;
    result_t         codes_due[$];
    int unsigned     errors, pixels, codes, frames, reg_writes;

    function new();
      width_reg  = FW_RESET;
      height_reg = FH_RESET;
      foreach (upper_row[i]) upper_row[i] = '0;
      foreach (middle_row[i]) middle_row[i] = '0;
      foreach (win[i, j]) win[i][j] = '0;
      row = 0;
      col = 0;
      errors = 0;
      pixels = 0;
      codes = 0;
      frames = 0;
      reg_writes = 0;
    endfunction

    function int unsigned eff_width();
      if (width_reg < MIN_SIDE) return MIN_SIDE;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int unsigned eff_height();
      if (height_reg < MIN_SIDE) return MIN_SIDE;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function int unsigned frame_pixels();
      return eff_width() * eff_height();
    endfunction

    function bit at_frame_start();
      return row == 0 && col == 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      reg_writes++;
      if (idx == CFG_FRAME_WIDTH) width_reg = data[FW_W-1:0];
      else if (idx == CFG_FRAME_HEIGHT) height_reg = data[FH_W-1:0];
    endfunction

    function void take_pixel(pixel_t px);
      int unsigned w, h, c;
      pixel_t      top, mid, ctr;
      result_t     due;
      w = eff_width();
      h = eff_height();
      c = col;
      pixels++;
      if (c >= MAX_WIDTH) c = 0;
      top = upper_row[c];
      mid = middle_row[c];
      upper_row[c] = mid;
      middle_row[c] = px;
      for (int i = 0; i < 3; i++) begin
        win[i][0] = win[i][1];
        win[i][1] = win[i][2];
      end
      win[0][2] = top;
      win[1][2] = mid;
      win[2][2] = px;
      if (row >= 2 && c >= 2) begin
        ctr = win[1][1];
        due.code[0] = win[0][0] >= ctr;
        due.code[1] = win[0][1] >= ctr;
        due.code[2] = win[0][2] >= ctr;
        due.code[3] = win[1][0] >= ctr;
        due.code[4] = win[1][2] >= ctr;
        due.code[5] = win[2][0] >= ctr;
        due.code[6] = win[2][1] >= ctr;
        due.code[7] = win[2][2] >= ctr;
        due.done = (row + 1 >= h) && (c + 1 >= w);
        codes_due = {codes_due, due};
      end
      if (c + 1 >= w) begin
        col = 0;
        row = (row + 1 >= h) ? 0 : (row + 1) & 'hFFF;
      end else begin
        col = (c + 1) & 'h3FF;
      end
    endfunction

    function void match_code(logic [7:0] code, logic done);
      result_t due;
      if (codes_due.size() == 0) begin
        $error("pattern_code %0d, frame_done %0b arrived with nothing expected", code, done);
        errors++;
        return;
      end
      due = codes_due.pop_front();
      codes++;
      if (code !== due.code) begin
        $error("pattern_code: expected %0d, got %0d", due.code, code);
        errors++;
      end
      if (done !== due.done) begin
        $error("frame_done: expected %0b, got %0b", due.done, done);
        errors++;
      end
      if (due.done) frames++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pixel_t                in_pixel = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [7:0]            out_pattern_code;
  logic                  out_frame_done;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  bit                    sender_calm = 1'b0;
  bit                    receiver_calm = 1'b0;
  bit                    hold_req = 1'b0;
  int unsigned           stall_left = 0;
  int unsigned           cycle_count = 0;
  lbp_window_tracker     tracker = new();

  lbp_3x3_code_stream_top dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_pixel         (in_pixel),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pattern_code (out_pattern_code),
    .out_frame_done   (out_frame_done),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int unsigned idle_len(bit quiet);
    int unsigned pick;
    if (quiet) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 65) return 0;
    if (pick < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ties around the centre are far likelier with a narrow band of values
  function automatic pixel_t rand_pixel();
    if ($urandom_range(0, 3) == 0) return pixel_t'($urandom_range(120, 123));
    return pixel_t'($urandom);
  endfunction

  task automatic send_pixel(pixel_t px);
    int unsigned gap;
    in_valid <= 1'b1;
    in_pixel <= px;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.take_pixel(px);
    gap = idle_len(sender_calm);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_pixels(int unsigned n);
    repeat (n) send_pixel(rand_pixel());
  endtask

  task automatic finish_frame();
    do send_pixel(rand_pixel()); while (!tracker.at_frame_start());
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.codes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(logic [CFG_DATA_W-1:0] wd, logic [CFG_DATA_W-1:0] hd);
    drain();
    cfg_write(CFG_FRAME_WIDTH, wd);
    cfg_write(CFG_FRAME_HEIGHT, hd);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        tracker.match_code(out_pattern_code, out_frame_done);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        n = idle_len(receiver_calm);
        out_ready <= (n == 0);
        stall_left = (n == 0) ? 0 : n - 1;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    pixel_t directed_px [18];
    int unsigned sent, n;
    logic [CFG_DATA_W-1:0] wd, hd;

    directed_px = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0,
                    8'd127, 8'd128, 8'd129, 8'd0, 8'd128, 8'd255, 8'd129, 8'd127, 8'd128};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unmapped indexes, then a 3x3 frame from clamped sizes
    cfg_write(CFG_SPARE_2, CFG_DATA_W'($urandom));
    cfg_write(CFG_SPARE_3, CFG_DATA_W'($urandom));
    set_frame(CFG_DATA_W'(0), CFG_DATA_W'(1));
    foreach (directed_px[i]) send_pixel(directed_px[i]);

    // width shrinks mid-frame past the current column
    set_frame(CFG_DATA_W'(10), CFG_DATA_W'(8));
    send_pixels(57);
    drain();
    cfg_write(CFG_FRAME_WIDTH, CFG_DATA_W'(5));
    finish_frame();

    // height shrinks mid-frame below the current row
    set_frame(CFG_DATA_W'(6), CFG_DATA_W'(12));
    send_pixels(42);
    drain();
    cfg_write(CFG_FRAME_HEIGHT, CFG_DATA_W'(4));
    finish_frame();

    // output held off while input streams, then a full pause mid-frame
    set_frame(CFG_DATA_W'(8), CFG_DATA_W'(6));
    sender_calm = 1'b1;
    hold_req = 1'b1;
    send_pixels(32);
    sender_calm = 1'b0;
    drain();
    send_pixels(16);

    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      drain();
      sender_calm = ($urandom_range(0, 4) == 0);
      receiver_calm = sender_calm;
      case ($urandom_range(0, 9))
        0:       wd = CFG_DATA_W'($urandom_range(0, 2));
        1:       wd = CFG_DATA_W'($urandom_range(13, 40));
        default: wd = CFG_DATA_W'($urandom_range(3, 12));
      endcase
      hd = ($urandom_range(0, 5) == 0) ? CFG_DATA_W'($urandom_range(0, 2))
                                       : CFG_DATA_W'($urandom_range(3, 8));
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_FRAME_WIDTH, wd);
      if ($urandom_range(0, 3) != 0) cfg_write(CFG_FRAME_HEIGHT, hd);
      n = tracker.frame_pixels() * $urandom_range(1, 3);
      if (n > RANDOM_PIXELS - sent) n = RANDOM_PIXELS - sent;
      send_pixels(n);
      sent += n;
    end
    drain();

    $display("Covered %0d pixels, %0d codes, %0d whole frames and %0d register writes.",
             tracker.pixels, tracker.codes, tracker.frames, tracker.reg_writes);
    $display("Sizes ran from clamped 3x3 up to 40 wide, with mid-frame resizing and stalls.");
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> lbp_3x3_code_stream_top.f
rtl/core/lbp_pkg.sv
rtl/core/lbp_ram.sv
rtl/core/lbp_window.sv
rtl/core/lbp_out_fifo.sv
rtl/core/lbp_3x3_code_stream_top.sv
sim/lbp_3x3_code_stream_tb.sv
